@@ rtl/spira_pkg.sv @@
// ----------------------------------------------------------------------------
// spira_pkg
// Shared types and codes for the SPI register access master.
// ----------------------------------------------------------------------------
package spira_pkg;

    // command codes carried in the func field
    localparam logic [1:0] FUNC_NONE   = 2'd0;
    localparam logic [1:0] FUNC_READ8  = 2'd1;
    localparam logic [1:0] FUNC_READ16 = 2'd2;
    localparam logic [1:0] FUNC_WRITE  = 2'd3;

    localparam int IN_TDATA_W  = 24;   // 17 payload bits, padded to bytes
    localparam int OUT_TDATA_W = 24;   // 21 payload bits, padded to bytes

    localparam logic [2:0] LAST_BIT       = 3'd7;
    localparam logic [1:0] BYTES_SHORT    = 2'd2;  // command + one byte
    localparam logic [1:0] BYTES_LONG     = 2'd3;  // command + two bytes

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_LOW  = 4'b0010,
        PH_HIGH = 4'b0100,
        PH_END  = 4'b1000
    } t_phase;

    typedef struct packed {
        logic       miso;
        logic [7:0] write_data;
        logic [5:0] reg_addr;
        logic [1:0] func;
    } t_cmd;

    typedef struct packed {
        logic [15:0] read_data;
        logic        done_res;
        logic        busy_res;
        logic        mosi;
        logic        sclk;
        logic        chip_select_n;
    } t_res;

endpackage

@@ rtl/spi_register_access_master_unit.sv @@
// ----------------------------------------------------------------------------
// spi_register_access_master_unit
// SPI master for single register reads and writes, one half-period per word.
// ----------------------------------------------------------------------------
// Words pass the input stage, then the result stage; one word per cycle
// while m_axis is ready; if a result waits, only into an empty input stage.
// The sequencer state in spira_core advances once per word, in order.
// Reset (i_rst_n low, synchronous): both stages empty, sequencer idle,
// chip select and clock high, MOSI low.
// ----------------------------------------------------------------------------
module spi_register_access_master_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // slave side
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // fields from bit 0: func[1:0], reg_addr[7:2], write_data[15:8], miso[16]
    input  logic [spira_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // master side
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // fields from bit 0: chip_select_n[0], sclk[1], mosi[2], busy_res[3],
    // done_res[4], read_data[20:5]
    output logic [spira_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import spira_pkg::*;

    // input stage
    logic  r_in_valid;
    t_cmd  r_in_cmd;

    // result stage
    logic  r_out_valid;
    t_res  r_out_res;

    logic  advance;   // result stage can take a new word
    logic  step;      // sequencer consumes the input stage this cycle
    t_res  core_res;

    assign advance       = ~r_out_valid | m_axis_tready;
    assign step          = advance & r_in_valid;
    assign s_axis_tready = ~r_in_valid | advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    // unpack the tick word; pad bits are ignored
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_cmd <= s_axis_tdata[$bits(t_cmd)-1:0];
        end
    end

    spira_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_cmd   (r_in_cmd),
        .o_res   (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_res <= core_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W - $bits(t_res)){1'b0}}, r_out_res};

endmodule

@@ rtl/spira_core.sv @@
// ----------------------------------------------------------------------------
// spira_core
// Transaction state and one tick of the SPI sequencer per step.
// ----------------------------------------------------------------------------
module spira_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  spira_pkg::t_cmd i_cmd,
    output spira_pkg::t_res o_res
);
    import spira_pkg::*;

    t_phase      r_phase,      n_phase;
    logic [2:0]  r_bit_count,  n_bit_count;
    logic [1:0]  r_byte_count, n_byte_count;
    logic [1:0]  r_operation,  n_operation;
    logic [7:0]  r_tx,         n_tx;
    logic [15:0] r_rx,         n_rx;
    logic [7:0]  r_held,       n_held;
    logic        r_cs_n,       n_cs_n;
    logic        r_sck,        n_sck;
    logic        r_mosi,       n_mosi;

    logic        done;
    logic [15:0] rdata;
    logic [1:0]  byte_inc;
    logic [1:0]  total;
    logic [7:0]  first_tx;

    always_comb begin
        n_phase      = r_phase;
        n_bit_count  = r_bit_count;
        n_byte_count = r_byte_count;
        n_operation  = r_operation;
        n_tx         = r_tx;
        n_rx         = r_rx;
        n_held       = r_held;
        n_cs_n       = r_cs_n;
        n_sck        = r_sck;
        n_mosi       = r_mosi;
        done         = 1'b0;
        rdata        = '0;
        byte_inc     = r_byte_count + 2'd1;
        total        = (r_operation == FUNC_READ16) ? BYTES_LONG : BYTES_SHORT;
        first_tx     = {i_cmd.reg_addr, (i_cmd.func == FUNC_WRITE), 1'b0};

        case (r_phase)
            PH_IDLE: begin
                if (i_cmd.func != FUNC_NONE) begin
                    n_operation  = i_cmd.func;
                    n_held       = i_cmd.write_data;
                    n_tx         = first_tx;
                    n_rx         = '0;
                    n_bit_count  = LAST_BIT;
                    n_byte_count = '0;
                    n_mosi       = first_tx[LAST_BIT];
                    n_cs_n       = 1'b0;
                    n_sck        = 1'b0;
                    n_phase      = PH_HIGH;
                end else begin
                    n_cs_n = 1'b1;
                    n_sck  = 1'b1;
                end
            end
            PH_LOW: begin
                n_mosi  = r_tx[r_bit_count];
                n_cs_n  = 1'b0;
                n_sck   = 1'b0;
                n_phase = PH_HIGH;
            end
            PH_HIGH: begin
                n_cs_n = 1'b0;
                n_sck  = 1'b1;
                // command byte MISO is dropped
                if (r_byte_count != 2'd0) begin
                    n_rx = {r_rx[14:0], i_cmd.miso};
                end
                if (r_bit_count == 3'd0) begin
                    n_byte_count = byte_inc;
                    if (byte_inc >= total) begin
                        n_phase = PH_END;
                    end else begin
                        n_tx        = (r_operation == FUNC_WRITE) ? r_held : 8'h00;
                        n_bit_count = LAST_BIT;
                        n_phase     = PH_LOW;
                    end
                end else begin
                    n_bit_count = r_bit_count - 3'd1;
                    n_phase     = PH_LOW;
                end
            end
            PH_END: begin
                n_cs_n  = 1'b1;
                n_sck   = 1'b1;
                done    = 1'b1;
                n_phase = PH_IDLE;
                if (r_operation == FUNC_READ8) begin
                    rdata = {8'h00, r_rx[7:0]};
                end else if (r_operation == FUNC_READ16) begin
                    rdata = r_rx;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    assign o_res.chip_select_n = n_cs_n;
    assign o_res.sclk          = n_sck;
    assign o_res.mosi          = n_mosi;
    assign o_res.busy_res      = ~n_cs_n;
    assign o_res.done_res      = done;
    assign o_res.read_data     = rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_bit_count  <= '0;
            r_byte_count <= '0;
            r_operation  <= FUNC_NONE;
            r_tx         <= '0;
            r_rx         <= '0;
            r_held       <= '0;
            r_cs_n       <= 1'b1;
            r_sck        <= 1'b1;
            r_mosi       <= 1'b0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_bit_count  <= n_bit_count;
            r_byte_count <= n_byte_count;
            r_operation  <= n_operation;
            r_tx         <= n_tx;
            r_rx         <= n_rx;
            r_held       <= n_held;
            r_cs_n       <= n_cs_n;
            r_sck        <= n_sck;
            r_mosi       <= n_mosi;
        end
    end

endmodule

@@ rtl/spira_checker.sv @@
// ----------------------------------------------------------------------------
// spira_checker
// Port-level checks for the SPI register access master, bound to the top.
// ----------------------------------------------------------------------------
module spira_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [spira_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import spira_pkg::*;

    logic cs_n, sck, busy, done;
    logic [15:0] rdata;

    assign cs_n  = m_axis_tdata[0];
    assign sck   = m_axis_tdata[1];
    assign busy  = m_axis_tdata[3];
    assign done  = m_axis_tdata[4];
    assign rdata = m_axis_tdata[20:5];

    // a stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result word changed under stall");

    // busy mirrors chip select
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (busy == !cs_n))
        else $error("busy does not follow chip select");

    // done only with select released and clock at rest
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && done |-> cs_n && sck)
        else $error("done without bus released");

    // read data only on the done word
    a_rdata: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (rdata != 16'h0000) |-> done)
        else $error("read data outside done");

    // clock stays high while select is high
    a_idle_sck: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && cs_n |-> sck)
        else $error("clock low while deselected");

endmodule

bind spi_register_access_master_unit spira_checker u_spira_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
